// ===== src/hbse_pkg.sv =====
// Shared types, mode tables and register map of the Hamming byte-stream encoder.
// Used by every module of the block; depends on nothing.

package hbse_pkg;

	localparam int MAX_DATA_BITS_DEF = 64;
	localparam int MODE_COUNT        = 5;
	localparam int CW_MAX_W          = 71;
	localparam int APB_DATA_W        = 32;
	localparam int APB_ADDR_W        = 3;

	// Register word index of code_mode.
	localparam logic REG_CODE_MODE = 1'b0;

	// code_mode values.
	localparam logic [2:0] MODE_K8  = 3'd0;
	localparam logic [2:0] MODE_K12 = 3'd1;
	localparam logic [2:0] MODE_K16 = 3'd2;
	localparam logic [2:0] MODE_K32 = 3'd3;
	localparam logic [2:0] MODE_K64 = 3'd4;

	// Control from the gather stage to the codeword holder.
	typedef struct packed {
		logic       load;
		logic [2:0] mode;
	} hbse_blk_t;

	// Data bits per block. An undefined mode reports a size that no build can reach.
	function automatic logic [6:0] mode_k(input logic [2:0] mode);
		logic [6:0] k;
		unique case (mode)
			MODE_K8:  k = 7'd8;
			MODE_K12: k = 7'd12;
			MODE_K16: k = 7'd16;
			MODE_K32: k = 7'd32;
			MODE_K64: k = 7'd64;
			default:  k = 7'd127;
		endcase
		return k;
	endfunction

	// Codeword length in bits.
	function automatic logic [6:0] mode_n(input logic [2:0] mode);
		logic [6:0] n;
		unique case (mode)
			MODE_K8:  n = 7'd12;
			MODE_K12: n = 7'd17;
			MODE_K16: n = 7'd21;
			MODE_K32: n = 7'd38;
			MODE_K64: n = 7'd71;
			default:  n = 7'd0;
		endcase
		return n;
	endfunction

	// Significant bits per output byte.
	function automatic logic [3:0] mode_bpb(input logic [2:0] mode);
		logic [3:0] b;
		unique case (mode)
			MODE_K8:  b = 4'd6;
			MODE_K12: b = 4'd1;
			MODE_K16: b = 4'd7;
			MODE_K32: b = 4'd2;
			MODE_K64: b = 4'd1;
			default:  b = 4'd1;
		endcase
		return b;
	endfunction

	// Output bytes per codeword.
	function automatic logic [6:0] mode_nbytes(input logic [2:0] mode);
		logic [6:0] nb;
		unique case (mode)
			MODE_K8:  nb = 7'd2;
			MODE_K12: nb = 7'd17;
			MODE_K16: nb = 7'd3;
			MODE_K32: nb = 7'd19;
			MODE_K64: nb = 7'd71;
			default:  nb = 7'd0;
		endcase
		return nb;
	endfunction

endpackage

// ===== src/hbse_byte_if.sv =====
// Input channel of the encoder: one raw byte per transfer.
// Stands alone; no package needed.

interface hbse_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/hbse_group_if.sv =====
// Output channel of the encoder: one group of up to eight code bytes per transfer.
// Stands alone; no package needed.

interface hbse_group_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last_group;

	modport source (output valid, output out_bytes, output byte_count, output last_group,
		input ready);
	modport sink   (input valid, input out_bytes, input byte_count, input last_group,
		output ready);
endinterface

// ===== src/hbse_gather.sv =====
// Bit gatherer: shifts input bytes into an accumulator and cuts out full data blocks.
// Depends on hbse_pkg and hbse_byte_if.

module hbse_gather import hbse_pkg::*; #(
	parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	hbse_byte_if.sink                byte_in,
	input  logic [2:0]               mode,
	input  logic                     cfg_clear,
	input  logic                     cw_free,
	output hbse_blk_t                blk_ctl,
	output logic [MAX_DATA_BITS-1:0] blk
);

	localparam int ACC_W = MAX_DATA_BITS + 8;

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_next;
	logic [6:0]       cnt_q;
	logic [6:0]       cnt_sum;
	logic [6:0]       rest;
	logic [6:0]       k;
	logic             mode_ok;
	logic             complete;
	logic             take;

	assign k        = mode_k(mode);
	assign mode_ok  = (k <= 7'(MAX_DATA_BITS));
	assign cnt_sum  = cnt_q + 7'd8;
	assign complete = (cnt_sum >= k);
	assign rest     = cnt_sum - k;
	assign acc_next = {acc_q[ACC_W-9:0], byte_in.data_byte};

	// An undefined mode swallows bytes; a completing byte waits for a free codeword slot.
	assign byte_in.ready = !mode_ok || !complete || cw_free;
	assign take          = byte_in.valid && byte_in.ready && mode_ok;

	// Fewer than eight bits remain after a cut, so the block shift is three bits wide.
	assign blk          = MAX_DATA_BITS'(acc_next >> rest[2:0]);
	assign blk_ctl.load = take && complete;
	assign blk_ctl.mode = mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_clear) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= complete ? rest : cnt_sum;
		end
	end

	// Bits above the count are never read, so the accumulator needs no clearing.
	always_ff @(posedge clk) begin
		if (take) begin
			acc_q <= acc_next;
		end
	end

endmodule

// ===== src/hbse_encode.sv =====
// Codeword builder: places data bits and even parity bits for every mode and selects one.
// Depends on hbse_pkg.

module hbse_encode import hbse_pkg::*; #(
	parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
	input  logic [2:0]                 mode,
	input  logic [MAX_DATA_BITS-1:0]   blk,
	output logic [MAX_DATA_BITS+6:0]   cw
);

	logic [63:0]         blk64;
	logic [CW_MAX_W-1:0] cw_mode [MODE_COUNT];

	assign blk64 = 64'(blk);

	// Bit pos-1 of a codeword holds position pos. Data fill the positions that are not
	// powers of two, first data bit lowest; parity p covers positions with bit p set.
	always_comb begin
		int         d;
		int         k;
		int         n;
		logic [CW_MAX_W-1:0] dat;
		logic       par;
		for (int m = 0; m < MODE_COUNT; m++) begin
			k   = int'(mode_k(3'(m)));
			n   = int'(mode_n(3'(m)));
			d   = 0;
			dat = '0;
			for (int pos = 1; pos <= CW_MAX_W; pos++) begin
				if (pos <= n && (pos & (pos - 1)) != 0) begin
					dat[pos-1] = blk64[6'(k - 1 - d)];
					d = d + 1;
				end
			end
			cw_mode[m] = dat;
			for (int p = 0; p < 7; p++) begin
				par = 1'b0;
				for (int pos = 1; pos <= CW_MAX_W; pos++) begin
					if (((pos >> p) & 1) != 0) begin
						par = par ^ dat[pos-1];
					end
				end
				if ((1 << p) <= n) begin
					cw_mode[m][(1 << p) - 1] = par;
				end
			end
		end
	end

	always_comb begin
		logic [CW_MAX_W-1:0] sel;
		unique case (mode)
			MODE_K8:  sel = cw_mode[0];
			MODE_K12: sel = cw_mode[1];
			MODE_K16: sel = cw_mode[2];
			MODE_K32: sel = cw_mode[3];
			MODE_K64: sel = cw_mode[4];
			default:  sel = '0;
		endcase
		cw = sel[MAX_DATA_BITS+6:0];
	end

endmodule

// ===== src/hbse_emit.sv =====
// Group emitter: holds one codeword and sends it out as groups of up to eight bytes.
// Depends on hbse_pkg and hbse_group_if.

module hbse_emit import hbse_pkg::*; #(
	parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hbse_blk_t                blk_ctl,
	input  logic [MAX_DATA_BITS+6:0] cw,
	output logic                     cw_free,
	hbse_group_if.source             group_out
);

	localparam int CW_W = MAX_DATA_BITS + 7;

	logic [CW_W-1:0] sh_q;
	logic [CW_W-1:0] sh_next;
	logic [2:0]      mode_q;
	logic [6:0]      rem_q;
	logic            cw_v_q;
	logic            out_v_q;
	logic [63:0]     out_bytes_q;
	logic [3:0]      count_q;
	logic            last_q;

	logic [63:0]     win;
	logic [63:0]     grp;
	logic [63:0]     grp_mode [MODE_COUNT];
	logic [3:0]      grp_count;
	logic            grp_last;
	logic            out_load;

	assign win = 64'(sh_q);

	// The earliest codeword bit of each byte lands in its most significant used bit.
	always_comb begin
		int bpb;
		for (int m = 0; m < MODE_COUNT; m++) begin
			bpb = int'(mode_bpb(3'(m)));
			grp_mode[m] = '0;
			for (int b = 0; b < 8; b++) begin
				for (int j = 0; j < 8; j++) begin
					if (j < bpb) begin
						grp_mode[m][b*8 + bpb - 1 - j] = win[b*bpb + j];
					end
				end
			end
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_K8:  grp = grp_mode[0];
			MODE_K12: grp = grp_mode[1];
			MODE_K16: grp = grp_mode[2];
			MODE_K32: grp = grp_mode[3];
			MODE_K64: grp = grp_mode[4];
			default:  grp = '0;
		endcase
	end

	// Only the one- and two-bit modes span several groups.
	always_comb begin
		unique case (mode_q)
			MODE_K32: sh_next = sh_q >> 16;
			default:  sh_next = sh_q >> 8;
		endcase
	end

	assign grp_last  = (rem_q <= 7'd8);
	assign grp_count = grp_last ? rem_q[3:0] : 4'd8;
	assign out_load  = cw_v_q && (!out_v_q || group_out.ready);
	assign cw_free   = !cw_v_q || (out_load && grp_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_v_q <= 1'b0;
		end else if (blk_ctl.load) begin
			cw_v_q <= 1'b1;
		end else if (out_load && grp_last) begin
			cw_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_ctl.load) begin
			sh_q   <= cw;
			mode_q <= blk_ctl.mode;
			rem_q  <= mode_nbytes(blk_ctl.mode);
		end else if (out_load) begin
			sh_q  <= sh_next;
			rem_q <= rem_q - 7'd8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (group_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bytes_q <= grp;
			count_q     <= grp_count;
			last_q      <= grp_last;
		end
	end

	assign group_out.valid      = out_v_q;
	assign group_out.out_bytes  = out_bytes_q;
	assign group_out.byte_count = count_q;
	assign group_out.last_group = last_q;

endmodule

// ===== src/hamming_byte_stream_encoder.sv =====
// Top level of the Hamming byte-stream encoder: register port and stage wiring.
// Depends on hbse_pkg, hbse_byte_if, hbse_group_if, hbse_gather, hbse_encode, hbse_emit.
//
//   channel    | direction | payload                                  | protocol
//   -----------+-----------+------------------------------------------+------------------
//   byte_in    | in        | data_byte[7:0]                           | valid/ready
//   group_out  | out       | out_bytes[63:0], byte_count[3:0], last   | valid/ready
//   APB        | in/out    | code_mode at word 0                      | setup + access
//
// A byte is taken in every cycle unless it completes a block while the emitter is busy; a
// completing byte is encoded in the same cycle into the codeword register. The first group
// enters the output register once that is empty or being read, and one group follows per
// cycle while the output is ready. A codeword holds the emitter until its last group (one,
// three or nine) is loaded. In the 64-bit mode nine groups follow every eight bytes.
// Reset clears the gathered bit count, the mode (to the 8-bit block size) and both valid
// flags; a write to code_mode also restarts block gathering. A stalled output holds its group.

module hamming_byte_stream_encoder import hbse_pkg::*; #(
	parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hbse_byte_if.sink             byte_in,
	hbse_group_if.source          group_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [2:0]               mode_q;
	logic                     cfg_clear;
	logic                     cw_free;
	hbse_blk_t                blk_ctl;
	logic [MAX_DATA_BITS-1:0] blk;
	logic [MAX_DATA_BITS+6:0] cw;

	// The register file has a single word. Byte-lane bits of the address are ignored,
	// and a write to any other word changes nothing.
	assign pready    = 1'b1;
	assign cfg_clear = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1] == REG_CODE_MODE);
	assign prdata    = (paddr[APB_ADDR_W-1] == REG_CODE_MODE)
		? APB_DATA_W'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_K8;
		end else if (cfg_clear) begin
			mode_q <= pwdata[2:0];
		end
	end

	// Gathering: bytes enter the accumulator, and a full block leaves combinationally.
	hbse_gather #(
		.MAX_DATA_BITS (MAX_DATA_BITS)
	) u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.mode      (mode_q),
		.cfg_clear (cfg_clear),
		.cw_free   (cw_free),
		.blk_ctl   (blk_ctl),
		.blk       (blk)
	);

	// Encoding: data placement and parity trees between the accumulator and codeword register.
	hbse_encode #(
		.MAX_DATA_BITS (MAX_DATA_BITS)
	) u_encode (
		.mode (mode_q),
		.blk  (blk),
		.cw   (cw)
	);

	// Emission: the codeword register is sliced into groups behind the output register.
	hbse_emit #(
		.MAX_DATA_BITS (MAX_DATA_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_ctl   (blk_ctl),
		.cw        (cw),
		.cw_free   (cw_free),
		.group_out (group_out)
	);

endmodule
